/* rtl/csvidx_pkg.sv */
// Package for the CSV line-id offset indexer.
// Holds the parser phase, result kinds, character codes and the queue record.
// Depends on nothing; every other file of the block but csvidx_if imports it.
package csvidx_pkg;

   localparam int QUEUE_DEPTH     = 4;
   localparam int QUEUE_PTR_WIDTH = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] CH_ZERO    = 8'd48;
   localparam logic [7:0] CH_NINE    = 8'd57;
   localparam logic [7:0] CH_COMMA   = 8'd44;
   localparam logic [7:0] CH_NEWLINE = 8'd10;

   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_START  = 2'd1,
      PH_DIGITS = 2'd2,
      PH_SKIP   = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      KIND_ENTRY     = 2'd0,
      KIND_END_OK    = 2'd1,
      KIND_END_EMPTY = 2'd2
   } kind_type;

   // One record per input item that causes results.
   typedef struct packed {
      logic        has_entry;
      logic        has_end;
      logic        empty_error;
      logic [63:0] entry_id;
      logic [63:0] line_offset;
      logic [63:0] entry_count;
   } record_type;

   typedef struct packed {
      logic push;
   } queue_wr_type;

   typedef struct packed {
      logic empty;
   } queue_rd_type;

endpackage

/* rtl/csvidx_if.sv */
// Valid/ready channel interfaces for the CSV line-id offset indexer.
// Depends on nothing.
interface csvidx_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_stream;

   modport source (output valid, output data_byte, output end_of_stream, input ready);
   modport sink (input valid, input data_byte, input end_of_stream, output ready);
endinterface

interface csvidx_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [63:0] entry_id;
   logic [63:0] line_offset;
   logic [63:0] entry_count;
   logic        last_of_run;

   modport source (output valid, output kind, output entry_id, output line_offset,
                   output entry_count, output last_of_run, input ready);
   modport sink (input valid, input kind, input entry_id, input line_offset,
                 input entry_count, input last_of_run, output ready);
endinterface

/* rtl/csv_line_id_offset_indexer.sv */
// CSV line-id offset indexer: reports, for every data line whose first column is a
// decimal id, the id, the line's byte offset and its entry number; an end-of-stream item
// flushes the last line and gives a summary. The byte input takes one item every cycle
// unless the queue is full; results leave one per cycle through an output register while
// the receiver is ready, and an end-of-stream item that also closes an entry gives two
// results. A four-record queue between parser and output absorbs these and output stalls.
// Depends on csvidx_pkg, csvidx_if, csvidx_front, csvidx_queue and csvidx_back.
module csv_line_id_offset_indexer
   import csvidx_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   csvidx_req_if.sink   req_bus,
   csvidx_rsp_if.source rsp_bus
);

   queue_wr_type wr_ctrl;
   queue_rd_type rd_status;
   record_type   wr_record;
   record_type   rd_record;
   logic         queue_full;
   logic         rd_pop;

   csvidx_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .wr_ctrl_out (wr_ctrl),
      .queue_full  (queue_full),
      .wr_record   (wr_record)
   );

   csvidx_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .wr_ctrl   (wr_ctrl),
      .wr_record (wr_record),
      .full      (queue_full),
      .rd_pop    (rd_pop),
      .rd_status (rd_status),
      .rd_record (rd_record)
   );

   csvidx_back u_back (
      .clock     (clock),
      .reset     (reset),
      .rd_status (rd_status),
      .rd_record (rd_record),
      .rd_pop    (rd_pop),
      .rsp_bus   (rsp_bus)
   );

endmodule

/* rtl/csvidx_front.sv */
// Front end: accepts bytes, tracks line state and offsets, and classifies each item.
// Items that cause results are pushed as one record into the queue.
// Depends on csvidx_pkg and csvidx_req_if.
module csvidx_front
   import csvidx_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   csvidx_req_if.sink        req_bus,
   output queue_wr_type      wr_ctrl_out,
   input  logic              queue_full,
   output record_type        wr_record
);

   phase_type   phase_ff, phase_in;
   logic [63:0] id_ff, id_in;
   logic [63:0] line_start_ff, line_start_in;
   logic [63:0] position_ff, position_in;
   logic [63:0] entries_ff, entries_in;
   logic        seen_ff, seen_in;

   logic        accept;
   logic        is_digit;
   logic [63:0] digit_ext;
   logic [63:0] id_times_ten;
   logic [63:0] position_next;
   logic        has_entry;
   logic        has_end;

   assign req_bus.ready = !queue_full;
   assign accept        = req_bus.valid && !queue_full;

   assign is_digit      = (req_bus.data_byte >= CH_ZERO) && (req_bus.data_byte <= CH_NINE);
   assign digit_ext     = {56'd0, req_bus.data_byte - CH_ZERO};
   assign id_times_ten  = {id_ff[60:0], 3'd0} + {id_ff[62:0], 1'b0};
   assign position_next = position_ff + 64'd1;

   always_comb begin
      phase_in      = phase_ff;
      id_in         = id_ff;
      line_start_in = line_start_ff;
      position_in   = position_ff;
      seen_in       = seen_ff;
      has_entry     = 1'b0;
      has_end       = 1'b0;
      if (req_bus.end_of_stream) begin
         has_entry     = (phase_ff == PH_DIGITS);
         has_end       = 1'b1;
         phase_in      = PH_HEADER;
         id_in         = '0;
         line_start_in = '0;
         position_in   = '0;
         seen_in       = 1'b0;
      end else begin
         seen_in     = 1'b1;
         position_in = position_next;
         if (req_bus.data_byte == CH_NEWLINE) begin
            has_entry     = (phase_ff == PH_DIGITS);
            phase_in      = PH_START;
            id_in         = '0;
            line_start_in = position_next;
         end else if ((phase_ff == PH_START) || (phase_ff == PH_DIGITS)) begin
            if (is_digit) begin
               id_in    = id_times_ten + digit_ext;
               phase_in = PH_DIGITS;
            end else begin
               has_entry = (phase_ff == PH_DIGITS) && (req_bus.data_byte == CH_COMMA);
               phase_in  = PH_SKIP;
            end
         end
      end
   end

   always_comb begin
      entries_in = entries_ff + {63'd0, has_entry};
      if (req_bus.end_of_stream) begin
         entries_in = '0;
      end
   end

   always_comb begin
      wr_record.has_entry   = has_entry;
      wr_record.has_end     = has_end;
      wr_record.empty_error = !seen_ff;
      wr_record.entry_id    = id_ff;
      wr_record.line_offset = line_start_ff;
      wr_record.entry_count = entries_ff + {63'd0, has_entry};
      wr_ctrl_out.push      = accept && (has_entry || has_end);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HEADER;
         id_ff         <= '0;
         line_start_ff <= '0;
         position_ff   <= '0;
         entries_ff    <= '0;
         seen_ff       <= 1'b0;
      end else if (accept) begin
         phase_ff      <= phase_in;
         id_ff         <= id_in;
         line_start_ff <= line_start_in;
         position_ff   <= position_in;
         entries_ff    <= entries_in;
         seen_ff       <= seen_in;
      end
   end

endmodule

/* rtl/csvidx_queue.sv */
// Short record queue between the front end and the back end.
// Depends on csvidx_pkg.
module csvidx_queue
   import csvidx_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  queue_wr_type wr_ctrl,
   input  record_type   wr_record,
   output logic         full,
   input  logic         rd_pop,
   output queue_rd_type rd_status,
   output record_type   rd_record
);

   record_type                 slots_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_WIDTH-1:0] count_ff, count_in;
   logic                       do_push;
   logic                       do_pop;

   assign full      = (count_ff == QUEUE_CNT_WIDTH'(QUEUE_DEPTH));
   assign do_push   = wr_ctrl.push && !full;
   assign do_pop    = rd_pop && (count_ff != '0);
   assign rd_record = slots_ff[rd_ptr_ff];

   always_comb begin
      rd_status.empty = (count_ff == '0);
      wr_ptr_in       = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in       = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in        = count_ff + QUEUE_CNT_WIDTH'(do_push) - QUEUE_CNT_WIDTH'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= wr_record;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* rtl/csvidx_back.sv */
// Back end: expands queued records into results and holds them in an output register.
// A record with an entry and an end gives two results, the entry first and then the end.
// Depends on csvidx_pkg and csvidx_rsp_if.
module csvidx_back
   import csvidx_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  queue_rd_type rd_status,
   input  record_type   rd_record,
   output logic         rd_pop,
   csvidx_rsp_if.source rsp_bus
);

   logic        valid_ff, valid_in;
   logic        entry_done_ff, entry_done_in;
   kind_type    kind_ff, kind_in;
   logic [63:0] id_ff, id_in;
   logic [63:0] offset_ff, offset_in;
   logic [63:0] count_ff, count_in;
   logic        last_ff, last_in;
   logic        load;

   assign load = !rd_status.empty && (!valid_ff || rsp_bus.ready);

   always_comb begin
      valid_in      = valid_ff && !rsp_bus.ready;
      entry_done_in = entry_done_ff;
      kind_in       = kind_ff;
      id_in         = id_ff;
      offset_in     = offset_ff;
      count_in      = count_ff;
      last_in       = last_ff;
      rd_pop        = 1'b0;
      if (load) begin
         valid_in = 1'b1;
         if (rd_record.has_entry && !entry_done_ff) begin
            kind_in   = KIND_ENTRY;
            id_in     = rd_record.entry_id;
            offset_in = rd_record.line_offset;
            count_in  = rd_record.entry_count;
            last_in   = !rd_record.has_end;
            if (rd_record.has_end) begin
               entry_done_in = 1'b1;
            end else begin
               rd_pop = 1'b1;
            end
         end else begin
            kind_in       = rd_record.empty_error ? KIND_END_EMPTY : KIND_END_OK;
            id_in         = '0;
            offset_in     = '0;
            count_in      = rd_record.empty_error ? 64'd0 : rd_record.entry_count;
            last_in       = 1'b1;
            entry_done_in = 1'b0;
            rd_pop        = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= 1'b0;
         entry_done_ff <= 1'b0;
      end else begin
         valid_ff      <= valid_in;
         entry_done_ff <= entry_done_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      id_ff     <= id_in;
      offset_ff <= offset_in;
      count_ff  <= count_in;
      last_ff   <= last_in;
   end

   assign rsp_bus.valid       = valid_ff;
   assign rsp_bus.kind        = kind_ff;
   assign rsp_bus.entry_id    = id_ff;
   assign rsp_bus.line_offset = offset_ff;
   assign rsp_bus.entry_count = count_ff;
   assign rsp_bus.last_of_run = last_ff;

endmodule
